@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTWD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define HTWD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

@@ rtl/core/htwd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_pkg
// Types and constants of the tree-walk decoder.
// ----------------------------------------------------------------------------
package htwd_pkg;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 9;
    localparam int SYM_W  = 8;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 32;
    localparam int BITCNT_W = $clog2(BYTE_W + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_DECODE = 2'd1,
        CMD_START  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             has_left;
        logic             has_right;
        logic [SYM_W-1:0] sym;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

endpackage

@@ rtl/core/htwd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_if
// Valid/ready channels: input items, decoded results, register writes.
// ----------------------------------------------------------------------------
interface htwd_item_if
    import htwd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] node_index;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic             has_left;
    logic             has_right;
    logic [SYM_W-1:0] leaf_symbol;
    logic [BYTE_W-1:0] data_byte;

    modport source (
        output valid, command, node_index, left_child, right_child,
               has_left, has_right, leaf_symbol, data_byte,
        input  ready
    );
    modport sink (
        input  valid, command, node_index, left_child, right_child,
               has_left, has_right, leaf_symbol, data_byte,
        output ready
    );
endinterface

interface htwd_result_if
    import htwd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             done_res;

    modport source (output valid, symbol, last, done_res, input ready);
    modport sink   (input  valid, symbol, last, done_res, output ready);
endinterface

interface htwd_cfg_if
    import htwd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input  valid, data, output ready);
endinterface

@@ rtl/core/htwd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module htwd_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/huffman_tree_walk_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Walks a loaded code tree over incoming bytes and emits decoded symbols.
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  item     in   command, node write fields, data byte
//  result   out  symbol, last, done_res
//  cfg      in   symbol_total
//
//  Node write and stream start are handled in the idle state, as is a data
//  byte that arrives with the count at zero. Any other data byte is walked:
//  fetch the current node, then a step for each code bit (each taken branch
//  needs a dependent read of the node table RAM), then check the node reached
//  by the last bit and hand the final symbol over; a stream that runs out
//  mid-byte stops early. Result back-pressure stretches this. The node table
//  holds no reset; it is valid once written. No item is taken while a byte
//  is being walked.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder
    import htwd_pkg::*;
#(
    parameter int MAX_NODES  = 512,
    parameter int COUNT_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    htwd_item_if.sink      item,
    htwd_result_if.source  result,
    htwd_cfg_if.sink       cfg
);

    localparam int AW    = $clog2(MAX_NODES);
    localparam int CMP_W = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam logic [CMP_W-1:0] NODE_LIM = CMP_W'(MAX_NODES);

    state_t                  state_reg, state_next;
    logic [CFG_W-1:0]        total_reg;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]           cur_reg, cur_next;
    node_t                   ent_reg, ent_next;
    node_t                   root_reg, root_next;
    logic                    fresh_reg, fresh_next;
    logic                    arrived_reg, arrived_next;
    logic [BYTE_W-1:0]       bits_reg, bits_next;
    logic [BITCNT_W-1:0]     bitcnt_reg, bitcnt_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]        pend_sym_reg, pend_sym_next;
    logic                    pend_done_reg, pend_done_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]        out_sym_reg, out_sym_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_done_reg, out_done_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    node_t                   ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [NODE_W-1:0]       ram_rdata;

    node_t                   ent;
    node_t                   ent_eff;
    logic [AW-1:0]           node_eff;
    logic                    is_leaf;
    logic                    out_free;
    logic                    done_now;
    logic                    bit_val;
    logic                    child_present;
    logic [IDX_W-1:0]        child;
    logic                    child_ok;
    logic                    item_fire;
    logic                    wr_ok;

    htwd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign item.ready      = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign result.valid    = out_valid_reg;
    assign result.symbol   = out_sym_reg;
    assign result.last     = out_last_reg;
    assign result.done_res = out_done_reg;

    assign item_fire = item.valid && item.ready;
    assign out_free  = !out_valid_reg || result.ready;

    // entry of the node in hand: straight from the RAM after a read
    assign ent      = fresh_reg ? node_t'(ram_rdata) : ent_reg;
    assign is_leaf  = arrived_reg && !ent.has_left && !ent.has_right;
    assign done_now = (cnt_reg == COUNT_BITS'(1));
    // after a leaf the walk resumes from the root in the same cycle
    assign ent_eff  = is_leaf ? root_reg : ent;
    assign node_eff = is_leaf ? '0 : cur_reg;

    assign bit_val       = bits_reg[BYTE_W-1];
    assign child_present = bit_val ? ent_eff.has_right : ent_eff.has_left;
    assign child         = bit_val ? ent_eff.right : ent_eff.left;
    assign child_ok      = child_present && (CMP_W'(child) < NODE_LIM);

    assign wr_ok = (CMP_W'(item.node_index) < NODE_LIM);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        ent_next        = ent_reg;
        root_next       = root_reg;
        fresh_next      = 1'b0;
        arrived_next    = arrived_reg;
        bits_next       = bits_reg;
        bitcnt_next     = bitcnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        ram_we          = 1'b0;
        ram_waddr       = AW'(item.node_index);
        ram_wdata       = '{left:      item.left_child,
                            right:     item.right_child,
                            has_left:  item.has_left,
                            has_right: item.has_right,
                            sym:       item.leaf_symbol};
        ram_raddr       = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    case (cmd_t'(item.command))
                        CMD_WRITE:
                        begin
                            if (wr_ok)
                            begin
                                ram_we = 1'b1;
                                if (item.node_index == '0)
                                begin
                                    root_next = ram_wdata;
                                end
                            end
                        end
                        CMD_START:
                        begin
                            cnt_next = COUNT_BITS'(total_reg);
                            cur_next = '0;
                        end
                        CMD_DECODE:
                        begin
                            if (cnt_reg != '0)
                            begin
                                fresh_next   = 1'b1;
                                arrived_next = 1'b0;
                                bits_next    = item.data_byte;
                                bitcnt_next  = BITCNT_W'(BYTE_W);
                                state_next   = ST_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                if (is_leaf && pend_valid_reg && !out_free)
                begin
                    // hold the fetched entry until the result side frees up
                    ent_next = ent;
                end
                else
                begin
                    if (is_leaf)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_sym_next   = pend_sym_reg;
                            out_last_next  = 1'b0;
                            out_done_next  = pend_done_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = ent.sym;
                        pend_done_next  = done_now;
                        cnt_next        = cnt_reg - COUNT_BITS'(1);
                    end
                    if ((is_leaf && done_now) || bitcnt_reg == '0)
                    begin
                        cur_next     = node_eff;
                        arrived_next = 1'b0;
                        state_next   = ST_FLUSH;
                    end
                    else
                    begin
                        bits_next   = {bits_reg[BYTE_W-2:0], 1'b0};
                        bitcnt_next = bitcnt_reg - BITCNT_W'(1);
                        if (child_ok)
                        begin
                            ram_raddr    = AW'(child);
                            cur_next     = AW'(child);
                            fresh_next   = 1'b1;
                            arrived_next = 1'b1;
                        end
                        else
                        begin
                            // absent branch: bit skipped
                            cur_next     = node_eff;
                            ent_next     = ent_eff;
                            arrived_next = 1'b0;
                        end
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sym_next    = pend_sym_reg;
                    out_last_next   = 1'b1;
                    out_done_next   = pend_done_reg;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            total_reg      <= '0;
            cnt_reg        <= '0;
            cur_reg        <= '0;
            fresh_reg      <= 1'b0;
            arrived_reg    <= 1'b0;
            bitcnt_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cur_reg        <= cur_next;
            fresh_reg      <= fresh_next;
            arrived_reg    <= arrived_next;
            bitcnt_reg     <= bitcnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                total_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg       <= ent_next;
        root_reg      <= root_next;
        bits_reg      <= bits_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        out_sym_reg   <= out_sym_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

endmodule

@@ rtl/core/htwd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htwd_checker
    import htwd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic [CMD_W-1:0] item_command,
    input logic             result_valid,
    input logic             result_ready,
    input logic [SYM_W-1:0] result_symbol,
    input logic             result_last,
    input logic             result_done_res
);

    // a result beat waits until it is taken
    `HTWD_ASSERT_NXT(a_res_hold, clk, rst_n, result_valid && !result_ready, result_valid)

    // a stalled beat keeps its payload
    `HTWD_ASSERT_NXT(a_res_stable, clk, rst_n, result_valid && !result_ready, $stable(result_symbol) && $stable(result_last) && $stable(result_done_res))

    // the symbol that ends the stream also ends its byte
    `HTWD_ASSERT_IMP(a_done_last, clk, rst_n, result_valid && result_done_res, result_last)

    // after a node write or stream start the decoder is ready again in the next cycle
    `HTWD_ASSERT_NXT(a_short_cmd, clk, rst_n, item_valid && item_ready && (item_command == CMD_WRITE || item_command == CMD_START), item_ready)

endmodule

bind huffman_tree_walk_decoder htwd_checker u_htwd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_command    (item.command),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_symbol   (result.symbol),
    .result_last     (result.last),
    .result_done_res (result.done_res)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tree-walk decoder. It loads code trees, starts
// streams and feeds data bytes under random idling on both channels. Every
// decoded symbol beat is checked against a bit-level model of the table walk.
// ----------------------------------------------------------------------------
module tb_top;
    import htwd_pkg::*;

    localparam int MAX_IDX      = 512;
    localparam int COUNT_W      = 32;
    localparam int RANDOM_ITEMS = 480;
    localparam int CALM_ITEMS   = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        cmd_t              command;
        logic [IDX_W-1:0]  node_index;
        logic [IDX_W-1:0]  left_child;
        logic [IDX_W-1:0]  right_child;
        logic              has_left;
        logic              has_right;
        logic [SYM_W-1:0]  leaf_symbol;
        logic [BYTE_W-1:0] data_byte;
    } item_beat_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             done_res;
    } sym_beat_t;

    logic clk;
    logic rst_n = 1'b0;

    htwd_item_if   item ();
    htwd_result_if result ();
    htwd_cfg_if    cfg ();

    huffman_tree_walk_decoder #(
        .MAX_NODES  (MAX_IDX),
        .COUNT_BITS (COUNT_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    // decoder model state
    node_t              decode_table [MAX_IDX];
    logic [IDX_W-1:0]   walk_node;
    logic [COUNT_W-1:0] symbols_remaining;
    logic [CFG_W-1:0]   total_cfg;

    // stimulus and scoreboard
    item_beat_t         item_queue[$];
    sym_beat_t          expected_syms[$];
    item_beat_t         on_bus;
    item_beat_t         next_beat;
    sym_beat_t          want;
    bit                 entry_known [MAX_IDX];
    logic [IDX_W-1:0]   known_list[$];
    int                 item_gap;
    int                 ready_hold;
    int                 fails = 0;
    int                 cycles = 0;
    bit                 calm = 1'b0;

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic node_t random_leaf();
        node_t n;
        n.left      = $urandom;
        n.right     = $urandom;
        n.has_left  = 1'b0;
        n.has_right = 1'b0;
        n.sym       = $urandom;
        return n;
    endfunction

    task automatic put_beat(input item_beat_t b);
        item.command     <= b.command;
        item.node_index  <= b.node_index;
        item.left_child  <= b.left_child;
        item.right_child <= b.right_child;
        item.has_left    <= b.has_left;
        item.has_right   <= b.has_right;
        item.leaf_symbol <= b.leaf_symbol;
        item.data_byte   <= b.data_byte;
    endtask

    task automatic push_node(input logic [IDX_W-1:0] idx, input node_t n);
        item_beat_t b;
        b.command     = CMD_WRITE;
        b.node_index  = idx;
        b.left_child  = n.left;
        b.right_child = n.right;
        b.has_left    = n.has_left;
        b.has_right   = n.has_right;
        b.leaf_symbol = n.sym;
        b.data_byte   = $urandom;
        item_queue.push_back(b);
        if (!entry_known[idx])
        begin
            entry_known[idx] = 1'b1;
            known_list.push_back(idx);
        end
    endtask

    // unused fields carry random values, the block must ignore them
    task automatic push_cmd(input cmd_t c, input logic [BYTE_W-1:0] data_v);
        item_beat_t b;
        b           = item_beat_t'({$urandom, $urandom});
        b.command   = c;
        b.data_byte = data_v;
        item_queue.push_back(b);
    endtask

    // noise node writes only point at entries already written
    task automatic push_noise();
        node_t n;
        case ($urandom_range(0, 2))
            0: push_cmd(CMD_NONE, $urandom);
            1: push_cmd(CMD_START, $urandom);
            default:
            begin
                n           = random_leaf();
                n.has_left  = $urandom;
                n.has_right = $urandom;
                if (n.has_left)
                    n.left = known_list[$urandom_range(0, known_list.size() - 1)];
                if (n.has_right)
                    n.right = known_list[$urandom_range(0, known_list.size() - 1)];
                push_node($urandom, n);
            end
        endcase
    endtask

    // grows a tree from the root by splitting leaves; now and then a node
    // gets a single child so that bits get skipped
    task automatic load_tree(input int leaves, output int written);
        logic [IDX_W-1:0] members[$];
        bit               in_tree [MAX_IDX];
        node_t            shape [MAX_IDX];
        int               leaf_cnt;
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        foreach (in_tree[i])
            in_tree[i] = 1'b0;
        members.push_back('0);
        in_tree[0] = 1'b1;
        shape[0]   = random_leaf();
        leaf_cnt   = 1;
        while (leaf_cnt < leaves)
        begin
            do
                p = members[$urandom_range(0, members.size() - 1)];
            while (shape[p].has_left || shape[p].has_right);
            do
                a = $urandom_range(1, MAX_IDX - 1);
            while (in_tree[a]);
            in_tree[a] = 1'b1;
            members.push_back(a);
            shape[a] = random_leaf();
            if ($urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    shape[p].right     = a;
                    shape[p].has_right = 1'b1;
                end
                else
                begin
                    shape[p].left     = a;
                    shape[p].has_left = 1'b1;
                end
            end
            else
            begin
                do
                    b = $urandom_range(1, MAX_IDX - 1);
                while (in_tree[b]);
                in_tree[b] = 1'b1;
                members.push_back(b);
                shape[b]           = random_leaf();
                shape[p].left      = a;
                shape[p].right     = b;
                shape[p].has_left  = 1'b1;
                shape[p].has_right = 1'b1;
                leaf_cnt++;
            end
        end
        foreach (members[i])
            push_node(members[i], shape[members[i]]);
        written = members.size();
    endtask

    task automatic predict_beat(input item_beat_t it);
        node_t            here;
        node_t            there;
        logic [IDX_W-1:0] step_to;
        logic             bit_v;
        logic             present;
        bit               stop;
        sym_beat_t        produced[$];
        sym_beat_t        one;
        stop = 1'b0;
        case (it.command)
            CMD_WRITE:
                decode_table[it.node_index] = '{it.left_child, it.right_child,
                                                it.has_left, it.has_right,
                                                it.leaf_symbol};
            CMD_START:
            begin
                symbols_remaining = total_cfg;
                walk_node         = '0;
            end
            CMD_DECODE:
                if (symbols_remaining != 0)
                begin
                    for (int b = BYTE_W - 1; b >= 0 && !stop; b--)
                    begin
                        bit_v   = it.data_byte[b];
                        here    = decode_table[walk_node];
                        present = bit_v ? here.has_right : here.has_left;
                        step_to = bit_v ? here.right : here.left;
                        if (present)
                        begin
                            walk_node = step_to;
                            there     = decode_table[step_to];
                            if (!there.has_left && !there.has_right)
                            begin
                                symbols_remaining = symbols_remaining - 1'b1;
                                walk_node         = '0;
                                one.symbol        = there.sym;
                                one.last          = 1'b0;
                                one.done_res      = (symbols_remaining == 0);
                                produced.push_back(one);
                                // rest of the byte is dropped once the count runs out
                                stop = (symbols_remaining == 0);
                            end
                        end
                    end
                    if (produced.size() != 0)
                    begin
                        one      = produced.pop_back();
                        one.last = 1'b1;
                        produced.push_back(one);
                    end
                    foreach (produced[i])
                        expected_syms.push_back(produced[i]);
                end
            default: ;
        endcase
    endtask

    // item driver; the model is stepped on every accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid        <= 1'b0;
            put_beat('0);
            on_bus            <= '0;
            item_gap          <= 0;
            walk_node         = '0;
            symbols_remaining = '0;
            total_cfg         = '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                total_cfg = cfg.data;
            if (item.valid && item.ready)
                predict_beat(on_bus);
            if (item.valid && !item.ready)
            begin
                // hold the beat until taken
            end
            else if (item_gap != 0)
            begin
                item_gap   <= item_gap - 1;
                item.valid <= 1'b0;
            end
            else if (item_queue.size() != 0 && !calm && $urandom_range(0, 7) == 0)
            begin
                item_gap   <= $urandom_range(0, 13);
                item.valid <= 1'b0;
            end
            else if (item_queue.size() != 0)
            begin
                next_beat = item_queue.pop_front();
                put_beat(next_beat);
                on_bus     <= next_beat;
                item.valid <= 1'b1;
            end
            else
                item.valid <= 1'b0;
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            ready_hold   <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_syms.size() == 0)
                begin
                    $error("symbol beat with none expected: symbol %0h", result.symbol);
                    fails++;
                end
                else
                begin
                    want = expected_syms.pop_front();
                    if (result.symbol !== want.symbol)
                    begin
                        $error("symbol: expected %0h, got %0h", want.symbol, result.symbol);
                        fails++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, result.last);
                        fails++;
                    end
                    if (result.done_res !== want.done_res)
                    begin
                        $error("done_res: expected %0b, got %0b",
                               want.done_res, result.done_res);
                        fails++;
                    end
                end
            end
            if (calm)
                result.ready <= 1'b1;
            else if (ready_hold != 0)
            begin
                ready_hold   <= ready_hold - 1;
                result.ready <= 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                ready_hold   <= $urandom_range(0, 13);
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    // idle once every beat is taken and every symbol is out, plus a tail for
    // bytes that decode to nothing
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (item_queue.size() != 0 || item.valid || expected_syms.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_total(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg.data  <= v;
        cfg.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        node_t            n;
        logic [CFG_W-1:0] phase_total;
        int               counted;
        int               phase;
        int               written;
        int               nbytes;

        cfg.valid        = 1'b0;
        cfg.data         = '0;
        foreach (entry_known[i])
            entry_known[i] = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: root written as a bare leaf first, so nothing reads an
        // unwritten entry
        write_total(32'd3);
        n = '{left: '1, right: '1, has_left: 1'b0, has_right: 1'b0, sym: 8'hAB};
        push_node(9'd0, n);
        push_cmd(CMD_DECODE, 8'hFF);            // count still zero
        push_cmd(CMD_START, 8'h00);
        push_cmd(CMD_DECODE, 8'h00);            // root without children
        push_cmd(CMD_DECODE, 8'hFF);
        push_cmd(CMD_NONE, 8'hFF);
        n = '{left: 9'd1, right: 9'd2, has_left: 1'b1, has_right: 1'b1, sym: 8'h00};
        push_node(9'd0, n);
        n = '{left: 9'd0, right: 9'd0, has_left: 1'b0, has_right: 1'b0, sym: 8'h00};
        push_node(9'd1, n);
        // one-sided node: a one bit here is skipped
        n = '{left: 9'd511, right: 9'd0, has_left: 1'b1, has_right: 1'b0, sym: 8'h5A};
        push_node(9'd2, n);
        n = '{left: '1, right: '1, has_left: 1'b0, has_right: 1'b0, sym: 8'hFF};
        push_node(9'd511, n);
        push_cmd(CMD_START, 8'h00);
        push_cmd(CMD_DECODE, 8'h00);            // count runs out mid-byte
        push_cmd(CMD_DECODE, 8'hFF);
        push_cmd(CMD_START, 8'h00);
        push_cmd(CMD_DECODE, 8'hFF);            // walk parks on the one-sided node
        push_cmd(CMD_DECODE, 8'h7F);
        push_cmd(CMD_DECODE, 8'h55);
        push_cmd(CMD_START, 8'h00);
        push_cmd(CMD_DECODE, 8'hAA);
        wait_quiet();

        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS)
        begin
            calm = (counted >= RANDOM_ITEMS - CALM_ITEMS);
            case (phase)
                0: phase_total = 32'hFFFF_FFFF;
                1: phase_total = 32'd0;
                2: phase_total = 32'd1;
                default:
                    phase_total = ($urandom_range(0, 5) == 0) ? $urandom
                                                              : $urandom_range(2, 40);
            endcase
            write_total(phase_total);
            load_tree($urandom_range(2, 12), written);
            counted += written;
            repeat ($urandom_range(3, 6))
            begin
                push_cmd(CMD_START, $urandom);
                counted++;
                nbytes = $urandom_range(1, 12);
                repeat (nbytes)
                begin
                    if ($urandom_range(0, 11) == 0)
                        push_noise();
                    push_cmd(CMD_DECODE, $urandom);
                    if (phase_total != 0)
                        counted++;
                end
            end
            wait_quiet();
            phase++;
        end

        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
